>>> rtl/one_shot_timer_bank_unit_defines.svh
// Assertion macros shared by the one-shot timer bank RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ONE_SHOT_TIMER_BANK_UNIT_DEFINES_SVH
`define ONE_SHOT_TIMER_BANK_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/osb_pkg.sv
// Package for the one-shot timer bank: sizes, request codes, controller
// states and the command/status structs between controller and datapath.
package osb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIMER_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int INDEX_W   = 3;
  localparam int PERIOD_W  = 32;
  localparam int ELAPSED_W = 16;
  localparam int COUNT_W   = 32;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } osb_state_t;

  typedef struct packed {
    logic tick_load;
    logic start_wr;
    logic scan_step;
    logic emit_step;
    logic idx_clr;
  } osb_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic mask_empty;
    logic cur_bit;
    logic out_free;
  } osb_sts_t;

endpackage

>>> rtl/osb_ifaces.sv
// Valid/ready channel interfaces for the one-shot timer bank.
// Depends on osb_pkg for the payload widths.
interface osb_in_if import osb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [INDEX_W-1:0]   timer_index;
  logic [PERIOD_W-1:0]  period_ms;
  logic [ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, req_type, timer_index, period_ms, elapsed_ms,
                  input ready);
  modport sink   (input valid, req_type, timer_index, period_ms, elapsed_ms,
                  output ready);
endinterface

interface osb_out_if import osb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] expired_index;
  logic               last_expiry;

  modport source (output valid, expired_index, last_expiry, input ready);
  modport sink   (input valid, expired_index, last_expiry, output ready);
endinterface

>>> rtl/one_shot_timer_bank_unit.sv
// One-shot timer bank, top level. A start item is accepted in idle and gives no result.
// A tick item scans one timer per cycle through the single add/compare unit, then walks the
// expiry mask one index per cycle up to the last expired timer, holding on a set bit until
// the output register is free. No new item is taken until the walk is done.
// Synchronous active-low reset disarms every timer and empties the output register.
module one_shot_timer_bank_unit import osb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  osb_in_if.sink    in_if,
  osb_out_if.source out_if
);

  osb_cmd_t cmd;
  osb_sts_t sts;

  osb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_req_type (in_if.req_type),
    .in_ready    (in_if.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  osb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_timer_index    (in_if.timer_index),
    .in_period_ms      (in_if.period_ms),
    .in_elapsed_ms     (in_if.elapsed_ms),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_expired_index (out_if.expired_index),
    .out_last_expiry   (out_if.last_expiry)
  );

endmodule

>>> rtl/osb_ctrl.sv
// Controller for the one-shot timer bank: idle, scan and emit phases.
// Depends on osb_pkg and the assertion macros in the defines header.
`include "one_shot_timer_bank_unit_defines.svh"

module osb_ctrl import osb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_ready,
  input  osb_sts_t sts,
  output osb_cmd_t cmd
);

  osb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_req_type == REQ_TICK)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.idx_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.mask_empty) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.start_wr  = in_valid && (in_req_type == REQ_START);
        cmd.tick_load = in_valid && (in_req_type == REQ_TICK);
        cmd.idx_clr   = in_valid && (in_req_type == REQ_TICK);
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.idx_clr   = sts.idx_last;
      end
      ST_EMIT: begin
        // A set bit waits for a free output slot; clear bits are skipped.
        cmd.emit_step = !sts.mask_empty && (!sts.cur_bit || sts.out_free);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `OSB_ASSERT_NEXT(a_scan_to_emit, (state_r == ST_SCAN) && sts.idx_last, state_r == ST_EMIT, "scan did not hand over to emit")
  `OSB_ASSERT_NEXT(a_emit_done, (state_r == ST_EMIT) && sts.mask_empty, state_r == ST_IDLE, "emit did not finish when no expiry was left")

endmodule

>>> rtl/osb_dp.sv
// Datapath for the one-shot timer bank: timer storage, scan counter,
// saturating add and compare, expiry mask and the output register.
// Depends on osb_pkg and the assertion macros in the defines header.
`include "one_shot_timer_bank_unit_defines.svh"

module osb_dp import osb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  osb_cmd_t             cmd,
  output osb_sts_t             sts,
  input  logic [INDEX_W-1:0]   in_timer_index,
  input  logic [PERIOD_W-1:0]  in_period_ms,
  input  logic [ELAPSED_W-1:0] in_elapsed_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [INDEX_W-1:0]   out_expired_index,
  output logic                 out_last_expiry
);

  logic [PERIOD_W-1:0]   period_r  [NUM_TIMERS];
  logic [COUNT_W-1:0]    elapsed_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed_r;
  logic [NUM_TIMERS-1:0] mask_r;
  logic [TIMER_W-1:0]    idx_r;
  logic [ELAPSED_W-1:0]  add_r;

  logic                 out_valid_r;
  logic [INDEX_W-1:0]   out_index_r;
  logic                 out_last_r;

  logic                 start_ok;
  logic [TIMER_W-1:0]   start_idx;
  logic [COUNT_W:0]     sum_wide;
  logic [COUNT_W-1:0]   sum_sat;
  logic                 hit;
  logic [NUM_TIMERS-1:0] idx_bit;
  logic                 last_flag;
  logic                 load_out;

  assign start_ok  = 32'(in_timer_index) < 32'(NUM_TIMERS);
  assign start_idx = TIMER_W'(in_timer_index);

  // Saturating add of the tick to the current timer's count.
  assign sum_wide = {1'b0, elapsed_r[idx_r]} + (COUNT_W + 1)'(add_r);
  assign sum_sat  = sum_wide[COUNT_W] ? {COUNT_W{1'b1}} : sum_wide[COUNT_W-1:0];
  assign hit      = armed_r[idx_r] && (sum_sat >= period_r[idx_r]);

  assign idx_bit   = NUM_TIMERS'(1) << idx_r;
  assign last_flag = (mask_r & ~idx_bit) == '0;
  assign load_out  = cmd.emit_step && mask_r[idx_r];

  assign sts.idx_last   = idx_r == TIMER_W'(NUM_TIMERS - 1);
  assign sts.mask_empty = mask_r == '0;
  assign sts.cur_bit    = mask_r[idx_r];
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start_wr && start_ok) begin
      period_r[start_idx]  <= in_period_ms;
      elapsed_r[start_idx] <= '0;
    end else if (cmd.scan_step && armed_r[idx_r]) begin
      elapsed_r[idx_r] <= sum_sat;
    end
    if (cmd.tick_load) begin
      add_r <= in_elapsed_ms;
    end
    if (load_out) begin
      out_index_r <= INDEX_W'(idx_r);
      out_last_r  <= last_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= '0;
      mask_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_wr && start_ok) begin
        armed_r[start_idx] <= 1'b1;
      end else if (cmd.scan_step && hit) begin
        armed_r[idx_r] <= 1'b0;
      end
      if (cmd.scan_step && hit) begin
        mask_r[idx_r] <= 1'b1;
      end else if (load_out) begin
        mask_r[idx_r] <= 1'b0;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.scan_step || cmd.emit_step) begin
        idx_r <= idx_r + TIMER_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_expired_index = out_index_r;
  assign out_last_expiry   = out_last_r;

  `OSB_ASSERT_NOW(a_emit_slot, cmd.emit_step && mask_r[idx_r], sts.out_free, "expiry loaded into a full output register")
  `OSB_ASSERT_NOW(a_expired_disarmed, mask_r[idx_r], !armed_r[idx_r], "pending expiry on an armed timer")
  `OSB_ASSERT_NEXT(a_last_drains, load_out && last_flag, mask_r == '0, "expiries left after the one marked last")

endmodule

>>> tb/sv/tb_one_shot_timer_bank_unit.sv
// Self-checking testbench for the one-shot timer bank: start and tick items, with
// expiry results predicted by a scoreboard class and checked in order.
// Depends on osb_pkg, the osb_in_if/osb_out_if interfaces and one_shot_timer_bank_unit.
module tb_one_shot_timer_bank_unit import osb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 126;
  localparam int unsigned QUIET_LIMIT  = 500;

  typedef struct packed {
    logic                 req_type;
    logic [INDEX_W-1:0]   timer_index;
    logic [PERIOD_W-1:0]  period_ms;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } timer_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] expired_index;
    logic               last_expiry;
  } expiry_t;

  // Mirrors the timer bank and holds the expiries that the block still owes.
  class expiry_board;
    bit                  armed   [NUM_TIMERS];
    logic [PERIOD_W-1:0] period  [NUM_TIMERS];
    logic [COUNT_W-1:0]  elapsed [NUM_TIMERS];
    expiry_t             due_q[$];
    int unsigned         errors, starts, ticks, checked;

    function new();
      foreach (armed[i]) begin
        armed[i]   = 1'b0;
        period[i]  = '0;
        elapsed[i] = '0;
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_request(timer_req_t r);
      logic [COUNT_W:0] sum;
      int               hit_q[$];
      if (r.req_type == REQ_START) begin
        starts++;
        if (r.timer_index < NUM_TIMERS) begin
          period[r.timer_index]  = r.period_ms;
          elapsed[r.timer_index] = '0;
          armed[r.timer_index]   = 1'b1;
        end
      end else begin
        ticks++;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (armed[i]) begin
            sum = {1'b0, elapsed[i]} + r.elapsed_ms;
            // The count sticks at all ones rather than wrapping.
            elapsed[i] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            if (elapsed[i] >= period[i]) begin
              armed[i] = 1'b0;
              hit_q.push_back(i);
            end
          end
        end
        foreach (hit_q[k])
          due_q.push_back(expiry_t'{expired_index: INDEX_W'(hit_q[k]),
                                    last_expiry: (k == hit_q.size() - 1)});
      end
    endfunction

    task check_expiry(logic [INDEX_W-1:0] idx, logic last);
      expiry_t want;
      if (due_q.size() == 0) begin
        report($sformatf("expiry of timer %0d with none expected", idx));
      end else begin
        want = due_q.pop_front();
        checked++;
        if (idx !== want.expired_index)
          report($sformatf("expired_index %0d, expected %0d", idx, want.expired_index));
        if (last !== want.last_expiry)
          report($sformatf("last_expiry %0b on timer %0d, expected %0b",
                           last, want.expired_index, want.last_expiry));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  bit          calm;
  int unsigned quiet_cycles;
  timer_req_t  taken_req;
  expiry_board board = new();

  osb_in_if  in_ch();
  osb_out_if out_ch();

  one_shot_timer_bank_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are sampled at the edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken_req = '{in_ch.req_type, in_ch.timer_index, in_ch.period_ms, in_ch.elapsed_ms};
        board.note_request(taken_req);
      end
      if (out_ch.valid && out_ch.ready)
        board.check_expiry(out_ch.expired_index, out_ch.last_expiry);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timed out after %0d cycles with no item moving.", QUIET_LIMIT);
    $display("tb_one_shot_timer_bank_unit failed");
    $finish;
  end

  // Result side: random stalls before each item unless the run is in a calm stretch.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic [INDEX_W-1:0] rnd_idx();
    return INDEX_W'($urandom);
  endfunction

  function automatic logic [PERIOD_W-1:0] rnd_per();
    return PERIOD_W'($urandom);
  endfunction

  function automatic logic [ELAPSED_W-1:0] rnd_el();
    return ELAPSED_W'($urandom);
  endfunction

  task automatic send_request(logic rq, logic [INDEX_W-1:0] idx,
                              logic [PERIOD_W-1:0] per, logic [ELAPSED_W-1:0] el);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rq;
    in_ch.timer_index <= idx;
    in_ch.period_ms   <= per;
    in_ch.elapsed_ms  <= el;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lowers valid and holds off until every predicted expiry has come back.
  task automatic wait_for_expiries();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic                 rq;
    logic [INDEX_W-1:0]   idx;
    logic [PERIOD_W-1:0]  per;
    logic [ELAPSED_W-1:0] el;

    rst_n             <= 1'b0;
    quiet_cycles      <= 0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_START;
    in_ch.timer_index <= '0;
    in_ch.period_ms   <= '0;
    in_ch.elapsed_ms  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Ticks on an empty bank, then a zero period that expires on a tick of 0 ms.
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'h0000);
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'hFFFF);
    send_request(REQ_START, INDEX_W'(0), 32'h0, rnd_el());
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'h0000);
    // A restart of a running timer clears its count.
    send_request(REQ_START, INDEX_W'(2), 32'd100, rnd_el());
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'd60);
    send_request(REQ_START, INDEX_W'(2), 32'd100, rnd_el());
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'd60);
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'd40);
    // All timers expire on one tick.
    for (int i = 0; i < NUM_TIMERS; i++)
      send_request(REQ_START, INDEX_W'(i), PERIOD_W'(i * 10), rnd_el());
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'd100);
    send_request(REQ_START, INDEX_W'(7), 32'hFFFF_FFFF, rnd_el());
    send_request(REQ_START, INDEX_W'(4), 32'd65535, rnd_el());
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'hFFFF);
    send_request(REQ_START, INDEX_W'(1), 32'd1, rnd_el());
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'h0000);
    send_request(REQ_TICK, rnd_idx(), rnd_per(), 16'd1);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 100 && k < 120);
      if (k == 60) wait_for_expiries();
      rq  = ($urandom_range(0, 9) < 5) ? REQ_START : REQ_TICK;
      idx = INDEX_W'($urandom_range(0, 7));
      per = rnd_per();
      el  = rnd_el();
      if (rq == REQ_START) begin
        case ($urandom_range(0, 3))
          0: per = '0;
          1: per = PERIOD_W'($urandom_range(0, 300));
          2: per = PERIOD_W'($urandom_range(0, 200000));
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: el = '0;
          1: el = ELAPSED_W'($urandom_range(0, 150));
          default: ;
        endcase
      end
      send_request(rq, idx, per, el);
    end
    calm = 1'b0;

    wait_for_expiries();
    repeat (2 * NUM_TIMERS + 4) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d expiries never arrived", board.pending()));

    $display("Run covered %0d starts and %0d ticks with %0d expiries checked,",
             board.starts, board.ticks, board.checked);
    $display("including restarts, zero periods, all-timer ticks and random stalls.");
    if (board.errors == 0) begin
      $display("tb_one_shot_timer_bank_unit passed");
    end else begin
      $display("tb_one_shot_timer_bank_unit failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/osb_pkg.sv
rtl/osb_ifaces.sv
rtl/osb_ctrl.sv
rtl/osb_dp.sv
rtl/one_shot_timer_bank_unit.sv
tb/sv/tb_one_shot_timer_bank_unit.sv
